// ===== src/incremental_pid_step_assert.svh =====
// assertion macros for the incremental pid step
`ifndef INCREMENTAL_PID_STEP_ASSERT_SVH
`define INCREMENTAL_PID_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define IPID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define IPID_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define IPID_ASSERT(label, prop, msg)
`define IPID_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ===== src/ipid_pkg.sv =====
// shared types, constants and microprogram of the incremental pid step
package ipid_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int GAIN_WIDTH_DEF   = 16;
    localparam int OUT_FRAC         = 16;
    localparam int GAIN_INT_BITS    = 4;
    localparam int ALPHA_W          = 16;
    localparam int ALPHA_FRAC       = 15;
    localparam int ALPHA_ONE        = 32768;
    localparam int ALPHA_HALF       = ALPHA_ONE / 2;
    localparam int LIMIT_W          = 31;
    localparam int OUT_W            = 32;
    localparam int KIND_W           = 2;
    localparam int CFG_AW           = 5;
    localparam int CFG_DW           = 32;
    localparam int PC_W             = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_STEP   = 2'd0,
        KIND_PRESET = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_GAIN_P_ERROR    = 3'd0,
        REG_GAIN_P_MEASURE  = 3'd1,
        REG_GAIN_I_PER_TICK = 3'd2,
        REG_GAIN_D_PER_TICK = 3'd3,
        REG_D_FILTER_WEIGHT = 3'd4,
        REG_OUTPUT_LIMIT    = 3'd5
    } t_reg;

    typedef enum logic [2:0] {X_DERR, X_DM, X_ERR, X_D2, X_DRAW, X_FD} t_xsel;
    typedef enum logic [2:0] {Y_GPE, Y_GPM, Y_GI, Y_GD, Y_ALPHA, Y_ALPHA_C} t_ysel;
    typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_LOAD_RND, ACC_ADD, ACC_SUB} t_acc_op;
    typedef enum logic [2:0] {DL_HOLD, DL_LOAD_Q, DL_ADD_Q, DL_ADD_FD, DL_SAT} t_dl_op;

    typedef struct packed {
        t_xsel            xsel;
        t_ysel            ysel;
        t_acc_op          acc_op;
        t_dl_op           dl_op;
        logic             wr_draw;
        logic             wr_fd;
        logic             jmp_other;
        logic [PC_W-1:0]  target;
        logic             fin_step;
        logic             fin_other;
    } t_uword;

    typedef struct packed {
        logic   fire;
        t_uword uw;
    } t_ctrl;

    typedef struct packed {
        logic is_step;
        logic out_free;
    } t_stat;

    localparam logic [PC_W-1:0] PC_OTHER = 4'd12;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            4'd0: begin
                w.xsel = X_DERR; w.ysel = Y_GPE;
                w.jmp_other = 1'b1; w.target = PC_OTHER;
            end
            4'd1: begin
                w.xsel = X_DM; w.ysel = Y_GPM; w.acc_op = ACC_LOAD;
            end
            4'd2: begin
                w.xsel = X_ERR; w.ysel = Y_GI; w.acc_op = ACC_SUB;
            end
            4'd3: begin
                w.xsel = X_D2; w.ysel = Y_GD; w.acc_op = ACC_LOAD; w.dl_op = DL_LOAD_Q;
            end
            4'd4: begin
                w.acc_op = ACC_LOAD; w.dl_op = DL_ADD_Q;
            end
            4'd5: begin
                w.wr_draw = 1'b1;
            end
            4'd6: begin
                w.xsel = X_DRAW; w.ysel = Y_ALPHA;
            end
            4'd7: begin
                w.xsel = X_FD; w.ysel = Y_ALPHA_C; w.acc_op = ACC_LOAD_RND;
            end
            4'd8: begin
                w.acc_op = ACC_ADD;
            end
            4'd9: begin
                w.wr_fd = 1'b1; w.dl_op = DL_ADD_FD;
            end
            4'd10: begin
                w.dl_op = DL_SAT;
            end
            4'd11: begin
                w.fin_step = 1'b1;
            end
            4'd12: begin
                w.fin_other = 1'b1;
            end
            default: begin
                w.fin_other = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== src/ipid_cfg.sv =====
// apb register bank for gains, filter weight and output limit
module ipid_cfg #(
    parameter int GAIN_WIDTH = ipid_pkg::GAIN_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [ipid_pkg::CFG_AW-1:0]        i_paddr,
    input  logic [ipid_pkg::CFG_DW-1:0]        i_pwdata,
    output logic [ipid_pkg::CFG_DW-1:0]        o_prdata,
    output logic                               o_pready,
    output logic signed [GAIN_WIDTH-1:0]       o_gpe,
    output logic signed [GAIN_WIDTH-1:0]       o_gpm,
    output logic signed [GAIN_WIDTH-1:0]       o_gi,
    output logic signed [GAIN_WIDTH-1:0]       o_gd,
    output logic [ipid_pkg::ALPHA_W-1:0]       o_alpha,
    output logic [ipid_pkg::LIMIT_W-1:0]       o_limit
);
    import ipid_pkg::*;

    logic [GAIN_WIDTH-1:0] r_gpe, r_gpm, r_gi, r_gd;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [LIMIT_W-1:0]    r_limit;
    t_reg                  w_idx;
    logic                  w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg'(i_paddr[CFG_AW-1:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpe   <= '0;
            r_gpm   <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_alpha <= ALPHA_W'(ALPHA_ONE);
            r_limit <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_GAIN_P_ERROR:    r_gpe   <= i_pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_P_MEASURE:  r_gpm   <= i_pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_I_PER_TICK: r_gi    <= i_pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_D_PER_TICK: r_gd    <= i_pwdata[GAIN_WIDTH-1:0];
                REG_D_FILTER_WEIGHT: r_alpha <= i_pwdata[ALPHA_W-1:0];
                REG_OUTPUT_LIMIT:    r_limit <= i_pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GAIN_P_ERROR:    o_prdata = {{(CFG_DW-GAIN_WIDTH){1'b0}}, r_gpe};
            REG_GAIN_P_MEASURE:  o_prdata = {{(CFG_DW-GAIN_WIDTH){1'b0}}, r_gpm};
            REG_GAIN_I_PER_TICK: o_prdata = {{(CFG_DW-GAIN_WIDTH){1'b0}}, r_gi};
            REG_GAIN_D_PER_TICK: o_prdata = {{(CFG_DW-GAIN_WIDTH){1'b0}}, r_gd};
            REG_D_FILTER_WEIGHT: o_prdata = {{(CFG_DW-ALPHA_W){1'b0}}, r_alpha};
            REG_OUTPUT_LIMIT:    o_prdata = {{(CFG_DW-LIMIT_W){1'b0}}, r_limit};
            default:             o_prdata = '0;
        endcase
    end

    assign o_gpe   = r_gpe;
    assign o_gpm   = r_gpm;
    assign o_gi    = r_gi;
    assign o_gd    = r_gd;
    assign o_alpha = r_alpha;
    assign o_limit = r_limit;

endmodule

// ===== src/ipid_seq.sv =====
// microprogram sequencer: step counter, control store and conditional jump
module ipid_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ipid_pkg::t_stat i_stat,
    output ipid_pkg::t_ctrl o_ctrl,
    output logic            o_busy
);
    import ipid_pkg::*;

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    t_uword          w_uw;
    logic            w_fin;
    logic            w_fire;

    assign w_uw   = ucode(r_pc);
    assign w_fin  = w_uw.fin_step || w_uw.fin_other;
    assign w_fire = r_busy && !(w_fin && !i_stat.out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
        end else if (w_fire) begin
            if (w_fin) begin
                r_busy <= 1'b0;
            end else if (w_uw.jmp_other && !i_stat.is_step) begin
                r_pc <= w_uw.target;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    assign o_ctrl.fire = w_fire;
    assign o_ctrl.uw   = w_uw;
    assign o_busy      = r_busy;

endmodule

// ===== src/ipid_dp.sv =====
// datapath: history registers, shared multiplier, accumulators, clamp and result register
module ipid_dp #(
    parameter int SAMPLE_WIDTH = ipid_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_WIDTH   = ipid_pkg::GAIN_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [ipid_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_target,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_measurement,
    input  logic signed [ipid_pkg::OUT_W-1:0]  i_preset,
    input  logic signed [GAIN_WIDTH-1:0]       i_gpe,
    input  logic signed [GAIN_WIDTH-1:0]       i_gpm,
    input  logic signed [GAIN_WIDTH-1:0]       i_gi,
    input  logic signed [GAIN_WIDTH-1:0]       i_gd,
    input  logic [ipid_pkg::ALPHA_W-1:0]       i_alpha,
    input  logic [ipid_pkg::LIMIT_W-1:0]       i_limit,
    input  ipid_pkg::t_ctrl                    i_ctrl,
    output ipid_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ipid_pkg::OUT_W-1:0]         o_data,
    output logic                               o_at_limit
);
    import ipid_pkg::*;

    localparam int DW   = SAMPLE_WIDTH + 2;
    localparam int EW   = SAMPLE_WIDTH + 1;
    localparam int XW   = OUT_W;
    localparam int YW   = (GAIN_WIDTH > ALPHA_W + 1) ? GAIN_WIDTH : ALPHA_W + 1;
    localparam int PW   = XW + YW;
    localparam int AW   = PW + 1;
    localparam int QS   = OUT_FRAC - (GAIN_WIDTH - GAIN_INT_BITS);
    localparam int LSH  = (QS > 0) ? QS : 0;
    localparam int RSH  = (QS < 0) ? -QS : 0;
    localparam int QW   = AW + LSH;
    localparam int SUMW = OUT_W + 2;

    localparam logic signed [QW-1:0]   QMAX = {{(QW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [QW-1:0]   QMIN = {{(QW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [SUMW-1:0] SMAX = {{(SUMW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SMIN = {{(SUMW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OMAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OMIN = {1'b1, {(OUT_W-1){1'b0}}};

    // controller state
    logic                           r_first;
    logic signed [EW-1:0]           r_perr;
    logic signed [SAMPLE_WIDTH-1:0] r_ps;
    logic signed [SAMPLE_WIDTH-1:0] r_sbp;
    logic signed [OUT_W-1:0]        r_fd;
    logic signed [OUT_W-1:0]        r_out_acc;

    // per item working registers
    logic [KIND_W-1:0]              r_kind;
    logic signed [EW-1:0]           r_err;
    logic signed [DW-1:0]           r_derr, r_dm, r_d2;
    logic signed [PW-1:0]           r_prod;
    logic signed [AW-1:0]           r_acc;
    logic signed [SUMW-1:0]         r_dl;
    logic signed [OUT_W-1:0]        r_draw;

    logic                           r_ovalid;
    logic [OUT_W-1:0]               r_odata;
    logic                           r_ouser;

    logic signed [SAMPLE_WIDTH-1:0] w_ps_eff, w_sbp_eff;
    logic signed [EW-1:0]           w_err;
    logic signed [DW-1:0]           w_derr, w_dm, w_d2;
    logic signed [ALPHA_W:0]        w_alpha, w_alpha_c;
    logic signed [XW-1:0]           w_x;
    logic signed [YW-1:0]           w_y;
    logic signed [PW-1:0]           w_prod;
    logic signed [QW-1:0]           w_q;
    logic signed [OUT_W-1:0]        w_qs;
    logic signed [AW-1:0]           w_acc_shr;
    logic signed [OUT_W-1:0]        w_fd_next;
    logic signed [OUT_W-1:0]        w_dl_sat;
    logic signed [SUMW-1:0]         w_sum, w_lim, w_nlim, w_res;
    logic                           w_at;

    // first step seeds the sample history with the measurement
    assign w_ps_eff  = r_first ? i_measurement : r_ps;
    assign w_sbp_eff = r_first ? i_measurement : r_sbp;
    assign w_err     = EW'(i_target) - EW'(i_measurement);
    assign w_derr    = DW'(w_err) - DW'(r_perr);
    assign w_dm      = DW'(i_measurement) - DW'(w_ps_eff);
    assign w_d2      = DW'(i_measurement) - (DW'(w_ps_eff) <<< 1) + DW'(w_sbp_eff);

    assign w_alpha   = (i_alpha > ALPHA_ONE) ? (ALPHA_W+1)'(ALPHA_ONE)
                                             : {1'b0, i_alpha};
    assign w_alpha_c = (ALPHA_W+1)'(ALPHA_ONE) - w_alpha;

    always_comb begin
        case (i_ctrl.uw.xsel)
            X_DERR:  w_x = XW'(r_derr);
            X_DM:    w_x = XW'(r_dm);
            X_ERR:   w_x = XW'(r_err);
            X_D2:    w_x = XW'(r_d2);
            X_DRAW:  w_x = r_draw;
            X_FD:    w_x = r_fd;
            default: w_x = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.uw.ysel)
            Y_GPE:     w_y = YW'(i_gpe);
            Y_GPM:     w_y = YW'(i_gpm);
            Y_GI:      w_y = YW'(i_gi);
            Y_GD:      w_y = YW'(i_gd);
            Y_ALPHA:   w_y = YW'(w_alpha);
            Y_ALPHA_C: w_y = YW'(w_alpha_c);
            default:   w_y = '0;
        endcase
    end

    assign w_prod = w_x * w_y;

    // move to q16.16 and saturate
    assign w_q  = (QW'(r_acc) <<< LSH) >>> RSH;
    assign w_qs = (w_q > QMAX) ? OMAX : ((w_q < QMIN) ? OMIN : w_q[OUT_W-1:0]);

    assign w_acc_shr = r_acc >>> ALPHA_FRAC;
    assign w_fd_next = w_acc_shr[OUT_W-1:0];
    assign w_dl_sat  = (r_dl > SMAX) ? OMAX : ((r_dl < SMIN) ? OMIN : r_dl[OUT_W-1:0]);

    assign w_sum  = SUMW'(r_out_acc) + r_dl;
    assign w_lim  = {{(SUMW-LIMIT_W){1'b0}}, i_limit};
    assign w_nlim = -w_lim;
    assign w_res  = (w_sum > w_lim) ? w_lim : ((w_sum < w_nlim) ? w_nlim : w_sum);
    assign w_at   = (w_res != w_sum);

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_start) begin
            r_kind <= i_kind;
            r_err  <= w_err;
            r_derr <= w_derr;
            r_dm   <= w_dm;
            r_d2   <= w_d2;
        end else if (i_ctrl.fire) begin
            case (i_ctrl.uw.acc_op)
                ACC_LOAD:     r_acc <= AW'(r_prod);
                ACC_LOAD_RND: r_acc <= AW'(r_prod) + AW'(ALPHA_HALF);
                ACC_ADD:      r_acc <= r_acc + AW'(r_prod);
                ACC_SUB:      r_acc <= r_acc - AW'(r_prod);
                default:      ;
            endcase
            case (i_ctrl.uw.dl_op)
                DL_LOAD_Q: r_dl <= SUMW'(w_qs);
                DL_ADD_Q:  r_dl <= r_dl + SUMW'(w_qs);
                DL_ADD_FD: r_dl <= r_dl + SUMW'(w_fd_next);
                DL_SAT:    r_dl <= SUMW'(w_dl_sat);
                default:   ;
            endcase
            if (i_ctrl.uw.wr_draw) begin
                r_draw <= w_qs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= 1'b1;
            r_perr    <= '0;
            r_ps      <= '0;
            r_sbp     <= '0;
            r_fd      <= '0;
            r_out_acc <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_ctrl.fire && (i_ctrl.uw.fin_step || i_ctrl.uw.fin_other)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_start) begin
                case (i_kind)
                    KIND_STEP: begin
                        r_first <= 1'b0;
                        r_perr  <= w_err;
                        r_sbp   <= w_ps_eff;
                        r_ps    <= i_measurement;
                    end
                    KIND_PRESET: begin
                        r_out_acc <= i_preset;
                    end
                    KIND_CLEAR: begin
                        r_first   <= 1'b1;
                        r_perr    <= '0;
                        r_ps      <= '0;
                        r_sbp     <= '0;
                        r_fd      <= '0;
                        r_out_acc <= '0;
                    end
                    default: ;
                endcase
            end else if (i_ctrl.fire) begin
                if (i_ctrl.uw.wr_fd) begin
                    r_fd <= w_fd_next;
                end
                if (i_ctrl.uw.fin_step) begin
                    r_out_acc <= w_res[OUT_W-1:0];
                    r_odata   <= w_res[OUT_W-1:0];
                    r_ouser   <= w_at;
                end else if (i_ctrl.uw.fin_other) begin
                    r_odata  <= r_out_acc;
                    r_ouser  <= 1'b0;
                end
            end
        end
    end

    assign o_stat.is_step  = (r_kind == KIND_STEP);
    assign o_stat.out_free = !r_ovalid || i_ready;
    assign o_valid         = r_ovalid;
    assign o_data          = r_odata;
    assign o_at_limit      = r_ouser;

endmodule

// ===== src/incremental_pid_step.sv =====
// Incremental PID step: each input beat is a control step, an output preset or a clear, and
// gives exactly one output beat with the Q16.16 output and a clamp flag. Work runs through a
// short microprogram on one shared 32 x 17 multiplier, a product accumulator and a delta
// register, so a control step holds the input side through its full microprogram, and a preset,
// clear or unused kind only through its first and its finishing microstep. Results wait in an
// output register, so the next beat is taken while a result is still unclaimed; the last
// microstep stalls only when that register is full and not being read. Gains, filter weight
// and limit sit on an APB port, written by the user while no item is in flight; not enforced.
`include "incremental_pid_step_assert.svh"
module incremental_pid_step #(
    parameter int SAMPLE_WIDTH = ipid_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_WIDTH   = ipid_pkg::GAIN_WIDTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // target, measurement, preset_value
    input  logic [((2*SAMPLE_WIDTH+ipid_pkg::OUT_W+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  logic [ipid_pkg::KIND_W-1:0]                 s_axis_tuser,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // control_output
    output logic [ipid_pkg::OUT_W-1:0]                  m_axis_tdata,
    // at_limit
    output logic [0:0]                                  m_axis_tuser,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [ipid_pkg::CFG_AW-1:0]                 paddr,
    input  logic [ipid_pkg::CFG_DW-1:0]                 pwdata,
    output logic [ipid_pkg::CFG_DW-1:0]                 prdata,
    output logic                                        pready
);
    import ipid_pkg::*;

    logic signed [GAIN_WIDTH-1:0] w_gpe, w_gpm, w_gi, w_gd;
    logic [ALPHA_W-1:0]           w_alpha;
    logic [LIMIT_W-1:0]           w_limit;
    t_ctrl                        w_ctrl;
    t_stat                        w_stat;
    logic                         w_busy;
    logic                         w_start;
    logic                         w_fin;

    assign s_axis_tready = !w_busy;
    assign w_start       = s_axis_tvalid && s_axis_tready;
    assign w_fin         = w_ctrl.fire && (w_ctrl.uw.fin_step || w_ctrl.uw.fin_other);

    ipid_cfg #(
        .GAIN_WIDTH(GAIN_WIDTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_gpe     (w_gpe),
        .o_gpm     (w_gpm),
        .o_gi      (w_gi),
        .o_gd      (w_gd),
        .o_alpha   (w_alpha),
        .o_limit   (w_limit)
    );

    ipid_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (w_busy)
    );

    ipid_dp #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .GAIN_WIDTH  (GAIN_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_kind        (s_axis_tuser),
        .i_target      (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_measurement (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .i_preset      (s_axis_tdata[2*SAMPLE_WIDTH+OUT_W-1:2*SAMPLE_WIDTH]),
        .i_gpe         (w_gpe),
        .i_gpm         (w_gpm),
        .i_gi          (w_gi),
        .i_gd          (w_gd),
        .i_alpha       (w_alpha),
        .i_limit       (w_limit),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_at_limit    (m_axis_tuser[0])
    );

    // one item in flight at a time
    `IPID_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while item in flight")
    // a new result appears only after a finishing microstep
    `IPID_ASSERT(a_out_src, $rose(m_axis_tvalid) |-> $past(w_fin), "result without finishing step")

endmodule
